// File: rtl/core/yuv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// shared types, coefficients and register codes for the 4:2:0 to rgb converter
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    // bt.601 coefficients scaled by 256
    localparam int COEF_Y  = 298;
    localparam int COEF_RV = 409;
    localparam int COEF_GU = 100;
    localparam int COEF_GV = 208;
    localparam int COEF_BU = 516;

    localparam int ROUND_BIAS    = 128;
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int CHAN_MAX      = 255;

    // signed widths of the products and the sums
    localparam int LUMA_TERM_W  = 18;
    localparam int RED_TERM_W   = 17;
    localparam int GREEN_TERM_W = 17;
    localparam int BLUE_TERM_W  = 18;
    localparam int SUM_W        = 20;

    localparam int PIXELS  = 4;
    localparam int PIXEL_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RED_SHIFT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_MASK    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_MASK  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_SHIFT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_MASK   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WIDE_PIXELS = 3'd6;

    // register reset values
    localparam logic [4:0]  RST_RED_SHIFT   = 5'd16;
    localparam logic [31:0] RST_RED_MASK    = 32'h00FF_0000;
    localparam logic [4:0]  RST_GREEN_SHIFT = 5'd8;
    localparam logic [31:0] RST_GREEN_MASK  = 32'h0000_FF00;
    localparam logic [4:0]  RST_BLUE_SHIFT  = 5'd0;
    localparam logic [31:0] RST_BLUE_MASK   = 32'h0000_00FF;
    localparam logic        RST_WIDE_PIXELS = 1'b1;

    localparam logic [31:0] NARROW_MASK = 32'h0000_FFFF;

    typedef logic [7:0] sample_t;

    // products after the first stage, stored as raw two's complement bits
    typedef struct packed {
        logic [PIXELS-1:0][LUMA_TERM_W-1:0] luma_term;
        logic [RED_TERM_W-1:0]              red_term;
        logic [GREEN_TERM_W-1:0]            green_term;
        logic [BLUE_TERM_W-1:0]             blue_term;
    } mult_stage_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t [PIXELS-1:0] pixel;
    } clamp_stage_t;

    typedef struct packed {
        logic [4:0]  red_shift;
        logic [31:0] red_mask;
        logic [4:0]  green_shift;
        logic [31:0] green_mask;
        logic [4:0]  blue_shift;
        logic [31:0] blue_mask;
        logic        wide_pixels;
    } pack_cfg_t;

endpackage

// File: rtl/core/yuv2rgb_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_mult
// first stage: offset removal and constant coefficient products
// ----------------------------------------------------------------------------
module yuv2rgb_mult (
    input  logic                        clk,
    input  logic                        load,
    input  yuv2rgb_pkg::sample_t        chroma_u,
    input  yuv2rgb_pkg::sample_t        chroma_v,
    input  yuv2rgb_pkg::sample_t [3:0]  luma,
    output yuv2rgb_pkg::mult_stage_t    terms
);

    yuv2rgb_pkg::mult_stage_t terms_reg;
    yuv2rgb_pkg::mult_stage_t terms_next;

    logic signed [8:0] d_val;
    logic signed [8:0] e_val;
    logic signed [8:0] c_val [yuv2rgb_pkg::PIXELS];

    logic signed [yuv2rgb_pkg::RED_TERM_W-1:0]   e_red;
    logic signed [yuv2rgb_pkg::GREEN_TERM_W-1:0] d_green;
    logic signed [yuv2rgb_pkg::GREEN_TERM_W-1:0] e_green;
    logic signed [yuv2rgb_pkg::BLUE_TERM_W-1:0]  d_blue;

    always_comb
    begin
        d_val = $signed({1'b0, chroma_u}) - 9'(yuv2rgb_pkg::CHROMA_OFFSET);
        e_val = $signed({1'b0, chroma_v}) - 9'(yuv2rgb_pkg::CHROMA_OFFSET);

        e_red   = {{(yuv2rgb_pkg::RED_TERM_W-9){e_val[8]}}, e_val};
        d_green = {{(yuv2rgb_pkg::GREEN_TERM_W-9){d_val[8]}}, d_val};
        e_green = {{(yuv2rgb_pkg::GREEN_TERM_W-9){e_val[8]}}, e_val};
        d_blue  = {{(yuv2rgb_pkg::BLUE_TERM_W-9){d_val[8]}}, d_val};

        terms_next.red_term = e_red
            * $signed(yuv2rgb_pkg::RED_TERM_W'(yuv2rgb_pkg::COEF_RV));
        terms_next.green_term =
            -(d_green * $signed(yuv2rgb_pkg::GREEN_TERM_W'(yuv2rgb_pkg::COEF_GU)))
            - (e_green * $signed(yuv2rgb_pkg::GREEN_TERM_W'(yuv2rgb_pkg::COEF_GV)));
        terms_next.blue_term = d_blue
            * $signed(yuv2rgb_pkg::BLUE_TERM_W'(yuv2rgb_pkg::COEF_BU));

        for (int k = 0; k < yuv2rgb_pkg::PIXELS; k++)
        begin
            c_val[k] = $signed({1'b0, luma[k]}) - 9'(yuv2rgb_pkg::LUMA_OFFSET);
            terms_next.luma_term[k] =
                $signed({{(yuv2rgb_pkg::LUMA_TERM_W-9){c_val[k][8]}}, c_val[k]})
                * $signed(yuv2rgb_pkg::LUMA_TERM_W'(yuv2rgb_pkg::COEF_Y));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// File: rtl/core/yuv2rgb_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_clamp
// second stage: channel sums, rounding, scale by 1/256 and saturation
// ----------------------------------------------------------------------------
module yuv2rgb_clamp (
    input  logic                       clk,
    input  logic                       load,
    input  yuv2rgb_pkg::mult_stage_t   terms,
    output yuv2rgb_pkg::clamp_stage_t  chans
);

    localparam int SW = yuv2rgb_pkg::SUM_W;

    yuv2rgb_pkg::clamp_stage_t chans_reg;
    yuv2rgb_pkg::clamp_stage_t chans_next;

    logic signed [SW-1:0] red_ext;
    logic signed [SW-1:0] green_ext;
    logic signed [SW-1:0] blue_ext;
    logic signed [SW-1:0] luma_ext [yuv2rgb_pkg::PIXELS];

    // floor divide by 256 then saturate to 0..255
    function automatic logic [7:0] sat8(input logic signed [SW-1:0] s);
        logic [7:0] res;
        if (s[SW-1])
        begin
            res = 8'd0;
        end
        else if (s[SW-2:16] != '0)
        begin
            res = 8'(yuv2rgb_pkg::CHAN_MAX);
        end
        else
        begin
            res = s[15:8];
        end
        return res;
    endfunction

    always_comb
    begin
        red_ext = {{(SW-yuv2rgb_pkg::RED_TERM_W){terms.red_term[yuv2rgb_pkg::RED_TERM_W-1]}},
                   terms.red_term};
        green_ext = {{(SW-yuv2rgb_pkg::GREEN_TERM_W)
                     {terms.green_term[yuv2rgb_pkg::GREEN_TERM_W-1]}}, terms.green_term};
        blue_ext = {{(SW-yuv2rgb_pkg::BLUE_TERM_W)
                    {terms.blue_term[yuv2rgb_pkg::BLUE_TERM_W-1]}}, terms.blue_term};
        for (int k = 0; k < yuv2rgb_pkg::PIXELS; k++)
        begin
            luma_ext[k] = {{(SW-yuv2rgb_pkg::LUMA_TERM_W)
                           {terms.luma_term[k][yuv2rgb_pkg::LUMA_TERM_W-1]}},
                           terms.luma_term[k]};
            chans_next.pixel[k].red   =
                sat8(luma_ext[k] + red_ext + SW'(yuv2rgb_pkg::ROUND_BIAS));
            chans_next.pixel[k].green =
                sat8(luma_ext[k] + green_ext + SW'(yuv2rgb_pkg::ROUND_BIAS));
            chans_next.pixel[k].blue  =
                sat8(luma_ext[k] + blue_ext + SW'(yuv2rgb_pkg::ROUND_BIAS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chans_reg <= chans_next;
        end
    end

    assign chans = chans_reg;

endmodule

// File: rtl/core/yuv2rgb_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_pack
// third stage: shift, mask and merge channels into packed pixels
// ----------------------------------------------------------------------------
module yuv2rgb_pack (
    input  logic                                              clk,
    input  logic                                              load,
    input  yuv2rgb_pkg::pack_cfg_t                            cfg,
    input  yuv2rgb_pkg::clamp_stage_t                         chans,
    output logic [yuv2rgb_pkg::PIXELS-1:0][yuv2rgb_pkg::PIXEL_W-1:0] pixels
);

    localparam int PW = yuv2rgb_pkg::PIXEL_W;

    logic [yuv2rgb_pkg::PIXELS-1:0][PW-1:0] pixels_reg;
    logic [yuv2rgb_pkg::PIXELS-1:0][PW-1:0] pixels_next;

    function automatic logic [PW-1:0] place(input logic [7:0]    chan,
                                            input logic [4:0]    shift,
                                            input logic [PW-1:0] mask);
        logic [PW-1:0] wide;
        wide = {{(PW-8){1'b0}}, chan};
        return (wide << shift) & mask;
    endfunction

    always_comb
    begin
        for (int k = 0; k < yuv2rgb_pkg::PIXELS; k++)
        begin
            pixels_next[k] = place(chans.pixel[k].red,   cfg.red_shift,   cfg.red_mask)
                           | place(chans.pixel[k].green, cfg.green_shift, cfg.green_mask)
                           | place(chans.pixel[k].blue,  cfg.blue_shift,  cfg.blue_mask);
            if (!cfg.wide_pixels)
            begin
                pixels_next[k] = pixels_next[k] & yuv2rgb_pkg::NARROW_MASK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixels_reg <= pixels_next;
        end
    end

    assign pixels = pixels_reg;

endmodule

// File: rtl/core/yuv420_to_packed_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_packed_rgb
// 4:2:0 chroma pair plus 2x2 luma group to four packed rgb pixels
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one u,v pair and four luma samples
//   per transfer. output channel: out_valid/out_ready carry the four packed
//   pixels of that group per transfer, in input order.
//   the three register stages (product stage, sum and saturate stage, pack
//   stage) each take a new group every cycle while the stage after it can
//   move, so throughput is one group per cycle while out_ready stays high.
//   stalls: each stage holds while the stage after it is full and not moving,
//   so a stalled receiver fills the pipeline and in_ready drops once all three
//   stages hold a group; nothing is dropped or repeated.
//   reset: empties the pipeline and loads the default rgb888 layout into the
//   configuration registers (red 23:16, green 15:8, blue 7:0, 32-bit pixels).
//   configuration: cfg_write_en writes cfg_data into register cfg_index
//   (0 red_shift, 1 red_mask, 2 green_shift, 3 green_mask, 4 blue_shift,
//   5 blue_mask, 6 wide_pixels); other indexes are ignored. write only while
//   the pipeline is empty.
// ----------------------------------------------------------------------------
module yuv420_to_packed_rgb (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  chroma_u,
    input  logic [7:0]  chroma_v,
    input  logic [7:0]  luma_top_left,
    input  logic [7:0]  luma_top_right,
    input  logic [7:0]  luma_bottom_left,
    input  logic [7:0]  luma_bottom_right,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_top_left,
    output logic [31:0] pixel_top_right,
    output logic [31:0] pixel_bottom_left,
    output logic [31:0] pixel_bottom_right
);

    // configuration registers
    yuv2rgb_pkg::pack_cfg_t cfg_reg;
    yuv2rgb_pkg::pack_cfg_t cfg_next;

    // stage valid bits
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    // a stage may take new data when it is empty or its data moves on
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    yuv2rgb_pkg::sample_t [3:0]  luma;
    yuv2rgb_pkg::mult_stage_t    terms;
    yuv2rgb_pkg::clamp_stage_t   chans;
    logic [yuv2rgb_pkg::PIXELS-1:0][yuv2rgb_pkg::PIXEL_W-1:0] pixels;

    // ---------------- configuration write ----------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                yuv2rgb_pkg::REG_RED_SHIFT:   cfg_next.red_shift   = cfg_data[4:0];
                yuv2rgb_pkg::REG_RED_MASK:    cfg_next.red_mask    = cfg_data;
                yuv2rgb_pkg::REG_GREEN_SHIFT: cfg_next.green_shift = cfg_data[4:0];
                yuv2rgb_pkg::REG_GREEN_MASK:  cfg_next.green_mask  = cfg_data;
                yuv2rgb_pkg::REG_BLUE_SHIFT:  cfg_next.blue_shift  = cfg_data[4:0];
                yuv2rgb_pkg::REG_BLUE_MASK:   cfg_next.blue_mask   = cfg_data;
                yuv2rgb_pkg::REG_WIDE_PIXELS: cfg_next.wide_pixels = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_shift   <= yuv2rgb_pkg::RST_RED_SHIFT;
            cfg_reg.red_mask    <= yuv2rgb_pkg::RST_RED_MASK;
            cfg_reg.green_shift <= yuv2rgb_pkg::RST_GREEN_SHIFT;
            cfg_reg.green_mask  <= yuv2rgb_pkg::RST_GREEN_MASK;
            cfg_reg.blue_shift  <= yuv2rgb_pkg::RST_BLUE_SHIFT;
            cfg_reg.blue_mask   <= yuv2rgb_pkg::RST_BLUE_MASK;
            cfg_reg.wide_pixels <= yuv2rgb_pkg::RST_WIDE_PIXELS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- pipeline control ----------------
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid     : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // ---------------- datapath ----------------
    assign luma[0] = luma_top_left;
    assign luma[1] = luma_top_right;
    assign luma[2] = luma_bottom_left;
    assign luma[3] = luma_bottom_right;

    // stage 1: coefficient products
    yuv2rgb_mult u_mult (
        .clk      (clk),
        .load     (s1_ready && in_valid),
        .chroma_u (chroma_u),
        .chroma_v (chroma_v),
        .luma     (luma),
        .terms    (terms)
    );

    // stage 2: sums, rounding and saturation
    yuv2rgb_clamp u_clamp (
        .clk   (clk),
        .load  (s2_ready && s1_valid_reg),
        .terms (terms),
        .chans (chans)
    );

    // stage 3: channel placement, also the output register
    yuv2rgb_pack u_pack (
        .clk    (clk),
        .load   (s3_ready && s2_valid_reg),
        .cfg    (cfg_reg),
        .chans  (chans),
        .pixels (pixels)
    );

    assign out_valid          = s3_valid_reg;
    assign pixel_top_left     = pixels[0];
    assign pixel_top_right    = pixels[1];
    assign pixel_bottom_left  = pixels[2];
    assign pixel_bottom_right = pixels[3];

`ifndef NO_ASSERTIONS
    // full pipeline with a stalled receiver must refuse input
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

    // a held middle stage keeps its group
    a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> s2_valid_reg)
        else $error("middle stage lost a group during a stall");

    // narrow mode leaves the upper half of each pixel clear
    a_narrow_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cfg_reg.wide_pixels && $stable(cfg_reg.wide_pixels))
        |-> (pixel_top_left[31:16] == 16'd0 && pixel_top_right[31:16] == 16'd0
             && pixel_bottom_left[31:16] == 16'd0 && pixel_bottom_right[31:16] == 16'd0))
        else $error("upper pixel bits set in 16-bit mode");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 4:2:0 to packed rgb converter
// ----------------------------------------------------------------------------
// drives 2x2 pixel groups through the valid/ready input channel and checks
// every output transfer against an in-bench bt.601 integer predictor. the
// packing registers are rewritten between traffic phases (default rgb888,
// swapped channels, 16-bit layouts, extreme shifts and masks, over-wide
// write data, unused index, random layouts). both channels idle in random
// bursts except during the closing phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_DEPTH  = 3;
    localparam int MAX_REPORTS = 10;

    // index that maps to no register, writes to it must be dropped
    localparam logic [yuv2rgb_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one input transfer: shared chroma pair plus four luma samples
    // luma / pixel order: 0 top left, 1 top right, 2 bottom left, 3 bottom right
    typedef struct packed {
        yuv2rgb_pkg::sample_t                           u;
        yuv2rgb_pkg::sample_t                           v;
        yuv2rgb_pkg::sample_t [yuv2rgb_pkg::PIXELS-1:0] luma;
    } yuv_group_t;

    typedef logic [yuv2rgb_pkg::PIXELS-1:0][yuv2rgb_pkg::PIXEL_W-1:0] pixel_quad_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the packing registers, predicts the four pixels of
    // each accepted group and checks output transfers in order
    // ------------------------------------------------------------------------
    class rgb_scoreboard;
        yuv2rgb_pkg::pack_cfg_t layout;
        pixel_quad_t            waiting[$];
        int                     errors;

        function new();
            layout.red_shift   = yuv2rgb_pkg::RST_RED_SHIFT;
            layout.red_mask    = yuv2rgb_pkg::RST_RED_MASK;
            layout.green_shift = yuv2rgb_pkg::RST_GREEN_SHIFT;
            layout.green_mask  = yuv2rgb_pkg::RST_GREEN_MASK;
            layout.blue_shift  = yuv2rgb_pkg::RST_BLUE_SHIFT;
            layout.blue_mask   = yuv2rgb_pkg::RST_BLUE_MASK;
            layout.wide_pixels = yuv2rgb_pkg::RST_WIDE_PIXELS;
            errors = 0;
        endfunction

        function void apply_reg(logic [yuv2rgb_pkg::REG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                yuv2rgb_pkg::REG_RED_SHIFT:   layout.red_shift   = data[4:0];
                yuv2rgb_pkg::REG_RED_MASK:    layout.red_mask    = data;
                yuv2rgb_pkg::REG_GREEN_SHIFT: layout.green_shift = data[4:0];
                yuv2rgb_pkg::REG_GREEN_MASK:  layout.green_mask  = data;
                yuv2rgb_pkg::REG_BLUE_SHIFT:  layout.blue_shift  = data[4:0];
                yuv2rgb_pkg::REG_BLUE_MASK:   layout.blue_mask   = data;
                yuv2rgb_pkg::REG_WIDE_PIXELS: layout.wide_pixels = data[0];
                default: ;
            endcase
        endfunction

        // floor divide by 256, then clamp to one byte
        function logic [7:0] saturate(int acc);
            int q;
            q = acc >>> 8;
            if (q < 0)
                return 8'd0;
            if (q > yuv2rgb_pkg::CHAN_MAX)
                return 8'hFF;
            return q[7:0];
        endfunction

        function logic [31:0] place(logic [7:0] chan, logic [4:0] sh, logic [31:0] m);
            logic [31:0] w;
            w = {24'd0, chan};
            return (w << sh) & m;
        endfunction

        function logic [31:0] pack_pixel(yuv2rgb_pkg::sample_t y, int d, int e);
            int          c;
            logic [31:0] px;
            c  = yuv2rgb_pkg::COEF_Y * (int'(y) - yuv2rgb_pkg::LUMA_OFFSET);
            px = place(saturate(c + yuv2rgb_pkg::COEF_RV * e + yuv2rgb_pkg::ROUND_BIAS),
                       layout.red_shift, layout.red_mask)
               | place(saturate(c - yuv2rgb_pkg::COEF_GU * d - yuv2rgb_pkg::COEF_GV * e
                                + yuv2rgb_pkg::ROUND_BIAS),
                       layout.green_shift, layout.green_mask)
               | place(saturate(c + yuv2rgb_pkg::COEF_BU * d + yuv2rgb_pkg::ROUND_BIAS),
                       layout.blue_shift, layout.blue_mask);
            if (!layout.wide_pixels)
                px = px & yuv2rgb_pkg::NARROW_MASK;
            return px;
        endfunction

        function void note_group(yuv_group_t g);
            pixel_quad_t want;
            int          d;
            int          e;
            d = int'(g.u) - yuv2rgb_pkg::CHROMA_OFFSET;
            e = int'(g.v) - yuv2rgb_pkg::CHROMA_OFFSET;
            for (int k = 0; k < yuv2rgb_pkg::PIXELS; k++)
                want[k] = pack_pixel(g.luma[k], d, e);
            waiting.push_back(want);
        endfunction

        function void check_quad(pixel_quad_t got);
            pixel_quad_t want;
            if (waiting.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output transfer: %h %h %h %h",
                             got[0], got[1], got[2], got[3]);
                return;
            end
            want = waiting.pop_front();
            for (int k = 0; k < yuv2rgb_pkg::PIXELS; k++)
            begin
                if (got[k] !== want[k])
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("pixel %0d mismatch: expected %h actual %h",
                                 k, want[k], got[k]);
                end
            end
        endfunction

        function int pending();
            return waiting.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports, the bench-driven ones known from time zero
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;

    logic        in_valid          = 1'b0;
    logic        in_ready;
    logic [7:0]  chroma_u          = '0;
    logic [7:0]  chroma_v          = '0;
    logic [7:0]  luma_top_left     = '0;
    logic [7:0]  luma_top_right    = '0;
    logic [7:0]  luma_bottom_left  = '0;
    logic [7:0]  luma_bottom_right = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;

    rgb_scoreboard board = new();

    // no idle bursts on either side once this is set
    bit quiet = 1'b0;
    int cycles = 0;
    int stall_left = 0;

    yuv420_to_packed_rgb uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .chroma_u           (chroma_u),
        .chroma_v           (chroma_v),
        .luma_top_left      (luma_top_left),
        .luma_top_right     (luma_top_right),
        .luma_bottom_left   (luma_bottom_left),
        .luma_bottom_right  (luma_bottom_right),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("yuv420_to_packed_rgb verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // output side: sample at the edge, check each transfer, then decide
    // whether ready is dropped for a random burst of cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_quad({pixel_bottom_right, pixel_bottom_left,
                                  pixel_top_right, pixel_top_left});
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall_left <= $urandom_range(1, 19) - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // sample value biased toward the range ends and the nominal video limits
    function automatic yuv2rgb_pkg::sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            default: return yuv2rgb_pkg::sample_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic yuv_group_t make_group(
        yuv2rgb_pkg::sample_t u,  yuv2rgb_pkg::sample_t v,
        yuv2rgb_pkg::sample_t y0, yuv2rgb_pkg::sample_t y1,
        yuv2rgb_pkg::sample_t y2, yuv2rgb_pkg::sample_t y3);
        yuv_group_t g;
        g.u    = u;
        g.v    = v;
        g.luma = {y3, y2, y1, y0};
        return g;
    endfunction

    // waits until every predicted group has come out
    task automatic wait_idle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // one register write per cycle; write enable is left high for the caller
    task automatic write_reg(input logic [yuv2rgb_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        board.apply_reg(idx, data);
    endtask

    // rewrites the whole packing layout once the pipeline is empty; the
    // unused index is hit first each time and must change nothing
    task automatic set_layout(input logic [31:0] rs, input logic [31:0] rm,
                              input logic [31:0] gs, input logic [31:0] gm,
                              input logic [31:0] bs, input logic [31:0] bm,
                              input logic [31:0] wide);
        wait_idle();
        write_reg(REG_UNUSED, $urandom());
        write_reg(yuv2rgb_pkg::REG_RED_SHIFT, rs);
        write_reg(yuv2rgb_pkg::REG_RED_MASK, rm);
        write_reg(yuv2rgb_pkg::REG_GREEN_SHIFT, gs);
        write_reg(yuv2rgb_pkg::REG_GREEN_MASK, gm);
        write_reg(yuv2rgb_pkg::REG_BLUE_SHIFT, bs);
        write_reg(yuv2rgb_pkg::REG_BLUE_MASK, bm);
        write_reg(yuv2rgb_pkg::REG_WIDE_PIXELS, wide);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // pushes a list of groups through the input channel; valid drops only for
    // an idle burst or after the last transfer
    task automatic play(input yuv_group_t items[$]);
        foreach (items[i])
        begin
            if (!quiet && $urandom_range(0, 6) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            in_valid          <= 1'b1;
            chroma_u          <= items[i].u;
            chroma_v          <= items[i].v;
            luma_top_left     <= items[i].luma[0];
            luma_top_right    <= items[i].luma[1];
            luma_bottom_left  <= items[i].luma[2];
            luma_bottom_right <= items[i].luma[3];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            board.note_group(items[i]);
        end
        in_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        yuv_group_t items[$];
        repeat (count)
            items.push_back(make_group(pick_sample(), pick_sample(), pick_sample(),
                                       pick_sample(), pick_sample(), pick_sample()));
        play(items);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        yuv_group_t corners[$];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed groups under the reset layout (rgb888, 32-bit pixels)
        corners.push_back(make_group(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        corners.push_back(make_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        // video black and white, neutral chroma
        corners.push_back(make_group(8'd128, 8'd128, 8'd16, 8'd235, 8'd16, 8'd235));
        corners.push_back(make_group(8'd128, 8'd128, 8'd0, 8'd255, 8'd17, 8'd234));
        // chroma extremes in all four combinations
        corners.push_back(make_group(8'd0, 8'd0, 8'd128, 8'd16, 8'd235, 8'd255));
        corners.push_back(make_group(8'd0, 8'd255, 8'd128, 8'd16, 8'd235, 8'd0));
        corners.push_back(make_group(8'd255, 8'd0, 8'd128, 8'd16, 8'd235, 8'd255));
        corners.push_back(make_group(8'd255, 8'd255, 8'd128, 8'd16, 8'd235, 8'd0));
        // red saturates high, blue goes negative
        corners.push_back(make_group(8'd0, 8'd255, 8'd255, 8'd200, 8'd100, 8'd0));
        // alternating bit patterns on every field
        corners.push_back(make_group(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
        corners.push_back(make_group(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        // just off neutral chroma, rounding edges
        corners.push_back(make_group(8'd127, 8'd129, 8'd1, 8'd15, 8'd254, 8'd236));
        corners.push_back(make_group(8'd129, 8'd127, 8'd128, 8'd127, 8'd129, 8'd64));
        play(corners);
        random_traffic(70);

        // swapped channel order
        set_layout(32'd0, 32'h0000_00FF, 32'd8, 32'h0000_FF00,
                   32'd16, 32'h00FF_0000, 32'd1);
        random_traffic(75);

        // 16-bit layout, upper halves must read zero
        set_layout(32'd8, 32'h0000_F800, 32'd3, 32'h0000_07E0,
                   32'd0, 32'h0000_001F, 32'd0);
        random_traffic(75);

        // largest shifts, full masks: most channel bits fall off the top
        set_layout(32'd31, 32'hFFFF_FFFF, 32'd31, 32'hFFFF_FFFF,
                   32'd31, 32'hFFFF_FFFF, 32'd1);
        random_traffic(60);

        // no shift and empty masks, narrow pixels
        set_layout(32'd0, 32'h0000_0000, 32'd0, 32'h0000_0000,
                   32'd0, 32'h0000_0000, 32'd0);
        random_traffic(60);

        // write data wider than the registers, only the low bits count
        set_layout(32'hFFFF_FFE4, $urandom(), 32'h0000_0129, $urandom(),
                   32'hABCD_EF71, $urandom(), 32'hFFFF_FFFE);
        random_traffic(75);

        // random layouts, overlapping channels included
        repeat (3)
        begin
            set_layout($urandom_range(0, 31), $urandom(), $urandom_range(0, 31),
                       $urandom(), $urandom_range(0, 31), $urandom(), 32'h3);
            random_traffic(35);
        end

        // closing phase: back to the reset layout, both sides run flat out
        set_layout(32'(yuv2rgb_pkg::RST_RED_SHIFT), yuv2rgb_pkg::RST_RED_MASK,
                   32'(yuv2rgb_pkg::RST_GREEN_SHIFT), yuv2rgb_pkg::RST_GREEN_MASK,
                   32'(yuv2rgb_pkg::RST_BLUE_SHIFT), yuv2rgb_pkg::RST_BLUE_MASK,
                   32'(yuv2rgb_pkg::RST_WIDE_PIXELS));
        quiet = 1'b1;
        random_traffic(80);

        wait_idle();
        repeat (PIPE_DEPTH * 4) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("yuv420_to_packed_rgb verification clean");
        else
            $display("yuv420_to_packed_rgb verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/yuv2rgb_pkg.sv
rtl/core/yuv2rgb_mult.sv
rtl/core/yuv2rgb_clamp.sv
rtl/core/yuv2rgb_pack.sv
rtl/core/yuv420_to_packed_rgb.sv
bench/tb_top.sv
